### sv/gbd_pkg.sv
`timescale 1ns / 1ps

package gbd_pkg;

  localparam int unsigned NodesDef   = 64;
  localparam int unsigned EntriesDef = 256;
  localparam int unsigned NodeW      = 6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_BFS = 2'd1,
    OP_DFS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NODE   = 2'd0,
    ST_STORED = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [NodeW-1:0] first_node;
    logic [NodeW-1:0] second_node;
    logic             one_way;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [NodeW-1:0] visited_node;
    logic             last;
  } out_item_t;

endpackage

### sv/gbd_if.sv
`timescale 1ns / 1ps

interface gbd_in_if import gbd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gbd_out_if import gbd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/gbd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module gbd_ram import gbd_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/graph_bfs_dfs_traversal.sv
`timescale 1ns / 1ps

// Channel  Dir  Port   Payload                                  Beat
// -------  ---  -----  ---------------------------------------  -------------------
// in       in   in_i   op, first_node, second_node, one_way     valid & ready high
// out      out  out_o  status, visited_node, last               valid & ready high
//
// An add edge holds the input through S_A_RD and S_A_WR, run once one-way and twice
// two-way, and through the final flush of the held result in S_FIN; a refused edge
// goes straight to S_FIN. During a walk, the single read port on the entry
// target/next memories sets the pace.
// Reset clears control state, list-empty flags and visited marks; memories are not
// cleared. A stalled output holds the sequencer once the one-result lookahead is full.

module graph_bfs_dfs_traversal import gbd_pkg::*; #(
  parameter int unsigned NODES   = NodesDef,
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbd_in_if.sink     in_i,
  gbd_out_if.source  out_o
);

  localparam int unsigned NIW = $clog2(NODES);       // node index
  localparam int unsigned SW  = $clog2(NODES + 1);   // queue pointers, 0..NODES
  localparam int unsigned EIW = $clog2(ENTRIES);     // entry index
  localparam int unsigned PW  = $clog2(ENTRIES + 1); // entry pointer incl. end mark

  localparam logic [PW-1:0]    NoEntry  = PW'(ENTRIES);
  localparam logic [NodeW:0]   NodesLim = (NodeW + 1)'(NODES);
  localparam logic [PW:0]      PoolLim  = (PW + 1)'(ENTRIES);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_A_RD  = 15'b000000000000010,
    S_A_WR  = 15'b000000000000100,
    S_B_INI = 15'b000000000001000,
    S_B_POP = 15'b000000000010000,
    S_B_NOD = 15'b000000000100000,
    S_B_HED = 15'b000000001000000,
    S_B_SC0 = 15'b000000010000000,
    S_B_SC1 = 15'b000000100000000,
    S_D_INI = 15'b000001000000000,
    S_D_HED = 15'b000010000000000,
    S_D_STP = 15'b000100000000000,
    S_D_POP = 15'b001000000000000,
    S_D_ENT = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // sequencer registers
  logic [NodeW-1:0] own_q, own_d;     // list owner during append
  logic [NodeW-1:0] tgt_q, tgt_d;     // appended neighbor
  logic             second_q, second_d;
  logic [NodeW-1:0] cur_q, cur_d;     // node being expanded
  logic [SW-1:0]    rd_q, rd_d, wr_q, wr_d;
  logic [NIW-1:0]   lvl_q, lvl_d;     // depth-first stack top level
  logic [PW-1:0]    top_q, top_d;     // resume position of the top level
  logic [PW-1:0]    used_q, used_d;
  logic [NODES-1:0] marks_q, marks_d;
  logic [NODES-1:0] hvalid_q, hvalid_d; // list nonempty
  logic             hrvld_q;            // nonempty flag aligned to head read

  // lookahead result and output register
  logic      hold_vld_q, hold_vld_d;
  out_item_t hold_q, hold_d;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;

  // memory ports
  logic             head_we, tail_we, tgt_we, nxt_we, work_we, res_we;
  logic [NIW-1:0]   head_waddr, head_raddr, tail_waddr, tail_raddr;
  logic [EIW-1:0]   head_wdata, tail_wdata, head_rdata, tail_rdata;
  logic [EIW-1:0]   tgt_waddr, nxt_waddr, ent_raddr;
  logic [NodeW-1:0] tgt_wdata, tgt_rdata;
  logic [PW-1:0]    nxt_wdata, nxt_rdata;
  logic [NIW-1:0]   work_waddr, work_raddr, res_waddr, res_raddr;
  logic [NodeW-1:0] work_wdata, work_rdata;
  logic [PW-1:0]    res_wdata, res_rdata;

  // emit control
  logic             emit_req, emit_ok, flush, out_free;
  logic [1:0]       emit_st;
  logic [NodeW-1:0] emit_node;

  logic [EIW-1:0]   slot;
  logic [PW:0]      pool_need;
  logic             tgt_new;

  assign out_free = !out_vld_q || out_o.ready;
  assign emit_ok  = !hold_vld_q || out_free;
  assign slot     = used_q[EIW-1:0];
  assign pool_need = {1'b0, used_q} + (PW + 1)'(in_i.data.one_way ? 1 : 2);
  // neighbor just read is a real node not yet seen
  assign tgt_new  = ({1'b0, tgt_rdata} < NodesLim) && !marks_q[tgt_rdata[NIW-1:0]];

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d    = state_q;
    own_d      = own_q;
    tgt_d      = tgt_q;
    second_d   = second_q;
    cur_d      = cur_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    lvl_d      = lvl_q;
    top_d      = top_q;
    used_d     = used_q;
    marks_d    = marks_q;
    hvalid_d   = hvalid_q;

    emit_req   = 1'b0;
    emit_st    = ST_NODE;
    emit_node  = '0;
    flush      = 1'b0;

    head_we    = 1'b0;
    head_waddr = own_q[NIW-1:0];
    head_wdata = slot;
    head_raddr = cur_q[NIW-1:0];
    tail_we    = 1'b0;
    tail_waddr = own_q[NIW-1:0];
    tail_wdata = slot;
    tail_raddr = own_q[NIW-1:0];
    tgt_we     = 1'b0;
    tgt_waddr  = slot;
    tgt_wdata  = tgt_q;
    nxt_we     = 1'b0;
    nxt_waddr  = slot;
    nxt_wdata  = NoEntry;
    ent_raddr  = top_q[EIW-1:0];
    work_we    = 1'b0;
    work_waddr = wr_q[NIW-1:0];
    work_wdata = tgt_rdata;
    work_raddr = rd_q[NIW-1:0];
    res_we     = 1'b0;
    res_waddr  = lvl_q;
    res_wdata  = nxt_rdata;
    res_raddr  = lvl_q - NIW'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          own_d    = in_i.data.first_node;
          tgt_d    = in_i.data.second_node;
          second_d = !in_i.data.one_way;
          cur_d    = in_i.data.first_node;
          unique case (in_i.data.op) inside
            OP_ADD: begin
              if (({1'b0, in_i.data.first_node} >= NodesLim) ||
                  ({1'b0, in_i.data.second_node} >= NodesLim) ||
                  (pool_need > PoolLim)) begin
                emit_req = 1'b1;
                emit_st  = ST_FULL;
                state_d  = S_FIN;
              end else begin
                state_d = S_A_RD;
              end
            end
            OP_BFS, OP_DFS: begin
              marks_d = '0;
              if ({1'b0, in_i.data.first_node} >= NodesLim) begin
                // walk from a node outside the graph reports only that node
                emit_req  = 1'b1;
                emit_node = in_i.data.first_node;
                state_d   = S_FIN;
              end else if (in_i.data.op == OP_BFS) begin
                state_d = S_B_INI;
              end else begin
                state_d = S_D_INI;
              end
            end
            default: ;
          endcase
        end
      end

      // append: claim entry, fetch owner's tail
      S_A_RD: begin
        tgt_we  = 1'b1;
        nxt_we  = 1'b1;
        state_d = S_A_WR;
      end

      // append: link entry behind the tail or make it the head
      S_A_WR: begin
        if (hvalid_q[own_q[NIW-1:0]]) begin
          nxt_we    = 1'b1;
          nxt_waddr = tail_rdata;
          nxt_wdata = used_q;
        end else begin
          head_we                     = 1'b1;
          hvalid_d[own_q[NIW-1:0]]    = 1'b1;
        end
        tail_we = 1'b1;
        used_d  = used_q + PW'(1);
        if (second_q) begin
          own_d    = tgt_q;
          tgt_d    = own_q;
          second_d = 1'b0;
          state_d  = S_A_RD;
        end else begin
          emit_req = 1'b1;
          emit_st  = ST_STORED;
          state_d  = S_FIN;
        end
      end

      S_B_INI: begin
        work_we                    = 1'b1;
        work_waddr                 = '0;
        work_wdata                 = cur_q;
        marks_d[cur_q[NIW-1:0]]    = 1'b1;
        rd_d                       = '0;
        wr_d                       = SW'(1);
        state_d                    = S_B_POP;
      end

      S_B_POP: begin
        if (rd_q == wr_q) begin
          state_d = S_FIN;
        end else begin
          rd_d    = rd_q + SW'(1);
          state_d = S_B_NOD;
        end
      end

      S_B_NOD: begin
        cur_d   = work_rdata;
        state_d = S_B_HED;
      end

      S_B_HED: begin
        emit_req  = 1'b1;
        emit_node = cur_q;
        if (emit_ok) begin
          state_d = S_B_SC0;
        end
      end

      S_B_SC0: begin
        ent_raddr = head_rdata;
        state_d   = hrvld_q ? S_B_SC1 : S_B_POP;
      end

      // one adjacency entry per cycle, next pointer feeds the read address
      S_B_SC1: begin
        ent_raddr = nxt_rdata[EIW-1:0];
        if (tgt_new && (wr_q != SW'(NODES))) begin
          marks_d[tgt_rdata[NIW-1:0]] = 1'b1;
          work_we                     = 1'b1;
          wr_d                        = wr_q + SW'(1);
        end
        if (nxt_rdata >= NoEntry) begin
          state_d = S_B_POP;
        end
      end

      S_D_INI: begin
        emit_req  = 1'b1;
        emit_node = cur_q;
        if (emit_ok) begin
          marks_d[cur_q[NIW-1:0]] = 1'b1;
          lvl_d                   = '0;
          state_d                 = S_D_HED;
        end
      end

      S_D_HED: begin
        top_d   = hrvld_q ? PW'(head_rdata) : NoEntry;
        state_d = S_D_STP;
      end

      S_D_STP: begin
        if (top_q >= NoEntry) begin
          if (lvl_q == '0) begin
            state_d = S_FIN;
          end else begin
            lvl_d   = lvl_q - NIW'(1);
            state_d = S_D_POP;
          end
        end else begin
          state_d = S_D_ENT;
        end
      end

      S_D_POP: begin
        top_d   = res_rdata;
        state_d = S_D_STP;
      end

      S_D_ENT: begin
        head_raddr = tgt_rdata[NIW-1:0];
        if (tgt_new && (lvl_q != NIW'(NODES - 1))) begin
          // descend: save where this level resumes, then open the neighbor's list
          emit_req  = 1'b1;
          emit_node = tgt_rdata;
          if (emit_ok) begin
            marks_d[tgt_rdata[NIW-1:0]] = 1'b1;
            res_we                      = 1'b1;
            lvl_d                       = lvl_q + NIW'(1);
            state_d                     = S_D_HED;
          end
        end else begin
          top_d   = nxt_rdata;
          state_d = S_D_STP;
        end
      end

      S_FIN: begin
        flush = 1'b1;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // one-result lookahead so the final beat can carry last
  always_comb begin
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_d      = out_q;
    if (emit_req && emit_ok) begin
      if (hold_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = hold_q;
        out_d.last = 1'b0;
      end
      hold_vld_d          = 1'b1;
      hold_d.status       = emit_st;
      hold_d.visited_node = emit_node;
      hold_d.last         = 1'b0;
    end
    if (flush && out_free) begin
      out_vld_d  = hold_vld_q;
      out_d      = hold_q;
      out_d.last = 1'b1;
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      marks_q    <= '0;
      hvalid_q   <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      second_q   <= 1'b0;
      rd_q       <= '0;
      wr_q       <= '0;
      lvl_q      <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      marks_q    <= marks_d;
      hvalid_q   <= hvalid_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      second_q   <= second_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      lvl_q      <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q   <= own_d;
    tgt_q   <= tgt_d;
    cur_q   <= cur_d;
    top_q   <= top_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
    hrvld_q <= hvalid_q[head_raddr];
  end

  gbd_ram #(.Width(EIW), .Depth(NODES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  gbd_ram #(.Width(EIW), .Depth(NODES)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_waddr), .wdata_i(tail_wdata),
    .raddr_i(tail_raddr), .rdata_o(tail_rdata)
  );

  gbd_ram #(.Width(NodeW), .Depth(ENTRIES)) u_target (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(tgt_wdata),
    .raddr_i(ent_raddr), .rdata_o(tgt_rdata)
  );

  gbd_ram #(.Width(PW), .Depth(ENTRIES)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(ent_raddr), .rdata_o(nxt_rdata)
  );

  gbd_ram #(.Width(NodeW), .Depth(NODES)) u_work (
    .clk_i, .we_i(work_we), .waddr_i(work_waddr), .wdata_i(work_wdata),
    .raddr_i(work_raddr), .rdata_o(work_rdata)
  );

  gbd_ram #(.Width(PW), .Depth(NODES)) u_resume (
    .clk_i, .we_i(res_we), .waddr_i(res_waddr), .wdata_i(res_wdata),
    .raddr_i(res_raddr), .rdata_o(res_rdata)
  );

endmodule
